// ----- sv/barometer_reading_compensation_macros.svh -----
// Assertion macros for the barometer reading compensation checker.
// Used by brc_checker.sv; needs clk_i and rst_ni in the including scope.
`ifndef BAROMETER_READING_COMPENSATION_MACROS_SVH
`define BAROMETER_READING_COMPENSATION_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define BRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define BRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- sv/brc_pkg.sv -----
// Package for the barometer reading compensation block: payload types,
// register indexes, formula constants and shift-based division helpers.
`timescale 1ns / 1ps

package brc_pkg;

  // Stages of each pipelined divider, one quotient bit per stage.
  localparam int unsigned DivStages = 32;

  // Configuration register indexes.
  localparam logic [2:0] RegAc1Ac2 = 3'd0;
  localparam logic [2:0] RegAc3Ac4 = 3'd1;
  localparam logic [2:0] RegAc5Ac6 = 3'd2;
  localparam logic [2:0] RegB1B2   = 3'd3;
  localparam logic [2:0] RegMcMd   = 3'd4;

  // Constants of the compensation formulas.
  localparam logic [31:0] TempOffset = 32'd4000;
  localparam logic [31:0] B7Scale    = 32'd50000;
  localparam logic [31:0] HalfRange  = 32'h8000_0000;
  localparam logic [31:0] PresSqK    = 32'd3038;
  localparam logic [31:0] PresLinK   = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] PresOffset = 32'd3791;
  localparam logic [31:0] B4Bias     = 32'd32768;

  typedef struct packed {
    logic [15:0] raw_temp;
    logic [15:0] raw_pressure;
  } brc_in_t;

  typedef struct packed {
    logic signed [31:0] temp_tenths;
    logic signed [31:0] pressure_pa;
    logic               div_error;
  } brc_out_t;

  // Sign extension of a 16-bit coefficient.
  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Signed division by 2^sh truncating toward zero.
  function automatic logic [31:0] sdiv_p2(input logic [31:0] a, input int unsigned sh);
    logic [31:0] bias;
    bias = a[31] ? ((32'd1 << sh) - 32'd1) : 32'd0;
    return 32'($signed(a + bias) >>> sh);
  endfunction

  // Magnitude of a two's complement value.
  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

endpackage

// ----- sv/brc_div.sv -----
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage.
// Depends on brc_pkg for the stage count.
`timescale 1ns / 1ps

module brc_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic [31:0] quotient_o
);
  import brc_pkg::*;

  logic [31:0] rem_q [1:DivStages-1];
  logic [31:0] num_q [1:DivStages];
  logic [31:0] den_q [1:DivStages-1];

  // Each stage shifts in one dividend bit and tries one subtraction.
  for (genvar k = 0; k < DivStages; k++) begin : g_step
    logic [31:0] r_in, n_in, d_in;
    logic [32:0] trial;
    logic [31:0] diff;
    logic        ge;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign n_in = dividend_i;
      assign d_in = divisor_i;
    end else begin : g_next
      assign r_in = rem_q[k];
      assign n_in = num_q[k];
      assign d_in = den_q[k];
    end

    // The remainder stays below the divisor, so the low 32 bits suffice.
    assign trial = {r_in, n_in[31]};
    assign diff  = trial[31:0] - d_in;
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k+1] <= {n_in[30:0], ge};
      end
    end

    if (k < DivStages - 1) begin : g_den
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1] <= ge ? diff : trial[31:0];
          den_q[k+1] <= d_in;
        end
      end
    end
  end

  assign quotient_o = num_q[DivStages];

endmodule

// ----- sv/barometer_reading_compensation.sv -----
// Barometer reading compensation: turns one raw temperature and one raw
// pressure sample into temperature in 0.1 degC and pressure in Pa using the
// ten calibration coefficients in the configuration registers. One reading is
// accepted every cycle unless the pipeline is stalled; each result passes through
// the two 32-stage dividers plus ten arithmetic and output stages.
// A full output register with stall high freezes the whole pipeline.
// Depends on brc_pkg and brc_div.
`timescale 1ns / 1ps

module barometer_reading_compensation (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  brc_pkg::brc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output brc_pkg::brc_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);
  import brc_pkg::*;

  typedef struct packed {
    logic        vld;
    logic [31:0] x1;
    logic        neg;
    logic        zero;
    logic [15:0] up;
  } side_a_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] temp;
    logic        err;
    logic        big;
  } side_b_t;

  // Configuration registers.
  logic [31:0] cal_q [0:4];
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) cal_q[i] <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegAc1Ac2: cal_q[0] <= cfg_data_i;
        RegAc3Ac4: cal_q[1] <= cfg_data_i;
        RegAc5Ac6: cal_q[2] <= cfg_data_i;
        RegB1B2:   cal_q[3] <= cfg_data_i;
        RegMcMd:   cal_q[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, cb1, cb2, mc, md;
  assign ac1 = sx16(cal_q[0][31:16]);
  assign ac2 = sx16(cal_q[0][15:0]);
  assign ac3 = sx16(cal_q[1][31:16]);
  assign ac4 = {16'd0, cal_q[1][15:0]};
  assign ac5 = {16'd0, cal_q[2][31:16]};
  assign ac6 = {16'd0, cal_q[2][15:0]};
  assign cb1 = sx16(cal_q[3][31:16]);
  assign cb2 = sx16(cal_q[3][15:0]);
  assign mc  = sx16(cal_q[4][31:16]);
  assign md  = sx16(cal_q[4][15:0]);

  // The whole pipeline moves unless a finished beat waits at the output.
  logic en;
  assign en         = ~(out_valid_o & out_stall_i);
  assign in_stall_o = ~en;

  // Stage 1: temperature product.
  logic        s1_vld_q;
  logic [31:0] s1_prod_q;
  logic [15:0] s1_up_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else if (en) s1_vld_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_prod_q <= ({16'd0, in_data_i.raw_temp} - ac6) * ac5;
      s1_up_q   <= in_data_i.raw_pressure;
    end
  end

  // Stage 2: signed MC*2048 / (X1 + MD) enters divider A.
  logic [31:0] s2_x1, s2_den, s2_num, qa;
  side_a_t     sa_q [0:DivStages-1];
  side_a_t     sa_d;

  assign s2_x1  = sdiv_p2(s1_prod_q, 15);
  assign s2_den = s2_x1 + md;
  assign s2_num = mc << 11;

  always_comb begin
    sa_d.vld  = s1_vld_q;
    sa_d.x1   = s2_x1;
    sa_d.neg  = s2_num[31] ^ s2_den[31];
    sa_d.zero = (s2_den == 32'd0);
    sa_d.up   = s1_up_q;
  end

  brc_div u_div_a (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (mag32(s2_num)),
    .divisor_i  (sa_d.zero ? 32'd1 : mag32(s2_den)),
    .quotient_o (qa)
  );

  // Side data travels alongside the divider stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DivStages; i++) sa_q[i] <= '0;
    end else if (en) begin
      sa_q[0] <= sa_d;
      for (int i = 1; i < DivStages; i++) sa_q[i] <= sa_q[i-1];
    end
  end

  // Stage 3: B5, temperature and B6.
  side_a_t     sa_o;
  logic [31:0] s3_b5;
  logic        s3_vld_q, s3_err_q;
  logic [31:0] s3_temp_q, s3_b6_q;
  logic [15:0] s3_up_q;

  assign sa_o  = sa_q[DivStages-1];
  assign s3_b5 = sa_o.x1 + (sa_o.neg ? (32'd0 - qa) : qa);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_vld_q <= 1'b0;
    else if (en) s3_vld_q <= sa_o.vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_err_q  <= sa_o.zero;
      s3_temp_q <= sdiv_p2(s3_b5 + 32'd8, 4);
      s3_b6_q   <= s3_b5 - TempOffset;
      s3_up_q   <= sa_o.up;
    end
  end

  // Stage 4: products of B6.
  logic        s4_vld_q, s4_err_q;
  logic [31:0] s4_temp_q, s4_b6b6_q, s4_ac2b6_q, s4_ac3b6_q;
  logic [15:0] s4_up_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_vld_q <= 1'b0;
    else if (en) s4_vld_q <= s3_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_err_q   <= s3_err_q;
      s4_temp_q  <= s3_temp_q;
      s4_up_q    <= s3_up_q;
      s4_b6b6_q  <= s3_b6_q * s3_b6_q;
      s4_ac2b6_q <= ac2 * s3_b6_q;
      s4_ac3b6_q <= ac3 * s3_b6_q;
    end
  end

  // Stage 5: scale the B6 products.
  logic        s5_vld_q, s5_err_q;
  logic [31:0] s5_temp_q, s5_b6sq_q, s5_x2a_q, s5_x1b_q;
  logic [15:0] s5_up_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s5_vld_q <= 1'b0;
    else if (en) s5_vld_q <= s4_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_err_q  <= s4_err_q;
      s5_temp_q <= s4_temp_q;
      s5_up_q   <= s4_up_q;
      s5_b6sq_q <= sdiv_p2(s4_b6b6_q, 12);
      s5_x2a_q  <= sdiv_p2(s4_ac2b6_q, 11);
      s5_x1b_q  <= sdiv_p2(s4_ac3b6_q, 13);
    end
  end

  // Stage 6: products of B6 squared.
  logic        s6_vld_q, s6_err_q;
  logic [31:0] s6_temp_q, s6_cb2_q, s6_cb1_q, s6_x2a_q, s6_x1b_q;
  logic [15:0] s6_up_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s6_vld_q <= 1'b0;
    else if (en) s6_vld_q <= s5_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_err_q  <= s5_err_q;
      s6_temp_q <= s5_temp_q;
      s6_up_q   <= s5_up_q;
      s6_cb2_q  <= cb2 * s5_b6sq_q;
      s6_cb1_q  <= cb1 * s5_b6sq_q;
      s6_x2a_q  <= s5_x2a_q;
      s6_x1b_q  <= s5_x1b_q;
    end
  end

  // Stage 7: B3 and the B4 factor.
  logic [31:0] s7_x3a, s7_x3b;
  logic        s7_vld_q, s7_err_q;
  logic [31:0] s7_temp_q, s7_b3_q, s7_t_q;
  logic [15:0] s7_up_q;

  assign s7_x3a = sdiv_p2(s6_cb2_q, 11) + s6_x2a_q;
  assign s7_x3b = sdiv_p2(s6_x1b_q + sdiv_p2(s6_cb1_q, 16) + 32'd2, 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s7_vld_q <= 1'b0;
    else if (en) s7_vld_q <= s6_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_err_q  <= s6_err_q;
      s7_temp_q <= s6_temp_q;
      s7_up_q   <= s6_up_q;
      s7_b3_q   <= sdiv_p2((ac1 << 2) + s7_x3a + 32'd2, 2);
      s7_t_q    <= s7_x3b + B4Bias;
    end
  end

  // Stage 8: B4 and B7.
  logic [31:0] s8_b4p;
  logic        s8_vld_q, s8_err_q;
  logic [31:0] s8_temp_q, s8_b4_q, s8_b7_q;

  assign s8_b4p = ac4 * s7_t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s8_vld_q <= 1'b0;
    else if (en) s8_vld_q <= s7_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_err_q  <= s7_err_q;
      s8_temp_q <= s7_temp_q;
      s8_b4_q   <= s8_b4p >> 15;
      s8_b7_q   <= ({16'd0, s7_up_q} - s7_b3_q) * B7Scale;
    end
  end

  // Stage 9: unsigned B7 / B4 enters divider B.
  logic        s9_zero, s9_big;
  logic [31:0] qb;
  side_b_t     sb_q [0:DivStages-1];
  side_b_t     sb_d;

  assign s9_zero = (s8_b4_q == 32'd0);
  assign s9_big  = (s8_b7_q >= HalfRange);

  always_comb begin
    sb_d.vld  = s8_vld_q;
    sb_d.temp = s8_temp_q;
    sb_d.err  = s8_err_q | s9_zero;
    sb_d.big  = s9_big;
  end

  brc_div u_div_b (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (s9_big ? s8_b7_q : (s8_b7_q << 1)),
    .divisor_i  (s9_zero ? 32'd1 : s8_b4_q),
    .quotient_o (qb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DivStages; i++) sb_q[i] <= '0;
    end else if (en) begin
      sb_q[0] <= sb_d;
      for (int i = 1; i < DivStages; i++) sb_q[i] <= sb_q[i-1];
    end
  end

  // Stage 10: P and its first products.
  side_b_t     sb_o;
  logic [31:0] s10_p, s10_x1;
  logic        s10_vld_q, s10_err_q;
  logic [31:0] s10_temp_q, s10_p_q, s10_sq_q, s10_lin_q;

  assign sb_o   = sb_q[DivStages-1];
  assign s10_p  = sb_o.big ? (qb << 1) : qb;
  assign s10_x1 = sdiv_p2(s10_p, 8);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s10_vld_q <= 1'b0;
    else if (en) s10_vld_q <= sb_o.vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s10_err_q  <= sb_o.err;
      s10_temp_q <= sb_o.temp;
      s10_p_q    <= s10_p;
      s10_sq_q   <= s10_x1 * s10_x1;
      s10_lin_q  <= PresLinK * s10_p;
    end
  end

  // Stage 11: second pressure product.
  logic        s11_vld_q, s11_err_q;
  logic [31:0] s11_temp_q, s11_p_q, s11_x1p_q, s11_x2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s11_vld_q <= 1'b0;
    else if (en) s11_vld_q <= s10_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s11_err_q  <= s10_err_q;
      s11_temp_q <= s10_temp_q;
      s11_p_q    <= s10_p_q;
      s11_x1p_q  <= s10_sq_q * PresSqK;
      s11_x2_q   <= sdiv_p2(s10_lin_q, 16);
    end
  end

  // Output register: final pressure sum and the error override.
  logic [31:0] s12_pres;
  logic        out_vld_q;
  brc_out_t    out_q;

  assign s12_pres = s11_p_q
                  + sdiv_p2(sdiv_p2(s11_x1p_q, 16) + s11_x2_q + PresOffset, 4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= s11_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.div_error   <= s11_err_q;
      out_q.temp_tenths <= s11_err_q ? 32'sd0 : $signed(s11_temp_q);
      out_q.pressure_pa <= s11_err_q ? 32'sd0 : $signed(s12_pres);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ----- sv/brc_checker.sv -----
// Port-level checker for barometer_reading_compensation, bound to the top.
// Depends on brc_pkg and barometer_reading_compensation_macros.svh.
`timescale 1ns / 1ps
`include "barometer_reading_compensation_macros.svh"

module brc_port_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input brc_pkg::brc_out_t out_data_o,
  input logic              cfg_ready_o
);
  import brc_pkg::*;

  // A stalled result beat stays in place.
  `BRC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result changed")

  // An error beat carries zero values.
  `BRC_ASSERT(a_err_zero, out_valid_o && out_data_o.div_error |-> out_data_o.temp_tenths == 0 && out_data_o.pressure_pa == 0, "error beat not zeroed")

  // The input side is held back exactly when a result beat is blocked.
  `BRC_ASSERT_ALWAYS(a_stall_link, in_stall_o == (out_valid_o && out_stall_i), "input stall mismatch")

  // The configuration port takes a write in every cycle.
  `BRC_ASSERT_ALWAYS(a_cfg_ready, cfg_ready_o, "configuration port not ready")

endmodule

bind barometer_reading_compensation brc_port_checker u_brc_checker (.*);

// ----- verif/brc_checker.sv -----
// Checker for the barometer reading compensation block: computes the expected
// compensated readings and compares them with every output beat.
// Depends on brc_pkg for the payload types and formula constants.
`timescale 1ns / 1ps

module brc_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  brc_pkg::brc_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  brc_pkg::brc_out_t out_data_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  output int                fail_count_o,
  output int                pending_o
);
  import brc_pkg::*;

  localparam int unsigned NumCalRegs = 5;

  logic [31:0] cal_q [NumCalRegs];
  brc_out_t    readings_q [$];

  // Signed 32-bit division truncating toward zero.
  function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? 32'd0 - a : a;
    mb = b[31] ? 32'd0 - b : b;
    q  = ma / mb;
    return (a[31] ^ b[31]) ? 32'd0 - q : q;
  endfunction

  function automatic logic [31:0] ext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Expected compensated reading for one sample under the current calibration.
  function automatic brc_out_t compensate(input brc_in_t d);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, cb1, cb2, mc, md, ut, up;
    logic [31:0] x1, x2, x3, b3, b5, b6, b6sq, b4, b7, p, t;
    brc_out_t r;
    ac1 = ext16(cal_q[RegAc1Ac2][31:16]);
    ac2 = ext16(cal_q[RegAc1Ac2][15:0]);
    ac3 = ext16(cal_q[RegAc3Ac4][31:16]);
    ac4 = {16'd0, cal_q[RegAc3Ac4][15:0]};
    ac5 = {16'd0, cal_q[RegAc5Ac6][31:16]};
    ac6 = {16'd0, cal_q[RegAc5Ac6][15:0]};
    cb1 = ext16(cal_q[RegB1B2][31:16]);
    cb2 = ext16(cal_q[RegB1B2][15:0]);
    mc  = ext16(cal_q[RegMcMd][31:16]);
    md  = ext16(cal_q[RegMcMd][15:0]);
    ut  = {16'd0, d.raw_temp};
    up  = {16'd0, d.raw_pressure};
    r   = '0;

    // Temperature path; a zero divisor aborts the whole reading.
    t  = (ut - ac6) * ac5;
    x1 = div_trunc(t, 32'd32768);
    x2 = x1 + md;
    if (x2 == 32'd0) begin
      r.div_error = 1'b1;
      return r;
    end
    t  = mc * 32'd2048;
    x2 = div_trunc(t, x2);
    b5 = x1 + x2;
    r.temp_tenths = div_trunc(b5 + 32'd8, 32'd16);

    // Pressure coefficients B3 and B4.
    b6   = b5 - TempOffset;
    t    = b6 * b6;
    b6sq = div_trunc(t, 32'd4096);
    t    = cb2 * b6sq;
    x1   = div_trunc(t, 32'd2048);
    t    = ac2 * b6;
    x2   = div_trunc(t, 32'd2048);
    x3   = x1 + x2;
    t    = ac1 * 32'd4 + x3 + 32'd2;
    b3   = div_trunc(t, 32'd4);
    t    = ac3 * b6;
    x1   = div_trunc(t, 32'd8192);
    t    = cb1 * b6sq;
    x2   = div_trunc(t, 32'd65536);
    x3   = div_trunc(x1 + x2 + 32'd2, 32'd4);
    t    = ac4 * (x3 + B4Bias);
    b4   = t >> 15;
    if (b4 == 32'd0) begin
      r = '0;
      r.div_error = 1'b1;
      return r;
    end

    // Unsigned B7 step, then the final pressure correction.
    b7 = (up - b3) * B7Scale;
    if (b7 < HalfRange) begin
      t = b7 * 32'd2;
      p = t / b4;
    end else begin
      t = b7 / b4;
      p = t * 32'd2;
    end
    x1 = div_trunc(p, 32'd256);
    x1 = x1 * x1;
    t  = x1 * PresSqK;
    x1 = div_trunc(t, 32'd65536);
    t  = PresLinK * p;
    x2 = div_trunc(t, 32'd65536);
    r.pressure_pa = p + div_trunc(x1 + x2 + PresOffset, 32'd16);
    return r;
  endfunction

  assign pending_o = readings_q.size();

  // Track configuration, queue predictions and compare output beats.
  always @(posedge clk_i or negedge rst_ni) begin
    brc_out_t want;
    if (!rst_ni) begin
      foreach (cal_q[i]) cal_q[i] = '0;
      readings_q.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (readings_q.size() == 0) begin
          $display("%0t: output beat with no reading pending: %h", $time, out_data_i);
          fail_count_o++;
        end else begin
          want = readings_q.pop_front();
          if (out_data_i.temp_tenths !== want.temp_tenths) begin
            $display("%0t: temp_tenths expected %0d actual %0d", $time,
                     want.temp_tenths, out_data_i.temp_tenths);
            fail_count_o++;
          end
          if (out_data_i.pressure_pa !== want.pressure_pa) begin
            $display("%0t: pressure_pa expected %0d actual %0d", $time,
                     want.pressure_pa, out_data_i.pressure_pa);
            fail_count_o++;
          end
          if (out_data_i.div_error !== want.div_error) begin
            $display("%0t: div_error expected %0b actual %0b", $time,
                     want.div_error, out_data_i.div_error);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) readings_q.push_back(compensate(in_data_i));
      if (cfg_valid_i && cfg_ready_i && cfg_index_i < NumCalRegs)
        cal_q[cfg_index_i] = cfg_data_i;
    end
  end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top for the barometer reading compensation block: drives readings
// and calibration writes, and reports the verdict from brc_checker.
// Depends on brc_pkg, brc_checker and the block itself.
`timescale 1ns / 1ps

module tb_top;
  import brc_pkg::*;

  localparam int NumPhases   = 8;
  localparam int DrainCycles = 100;
  localparam int StuckLimit  = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  brc_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  brc_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = RegAc1Ac2;
  logic [31:0] cfg_data = '0;
  logic        calm = 1'b0;
  int          fail_count;
  int          pending;
  int          readings_sent = 0;
  int          stuck_cycles = 0;

  barometer_reading_compensation i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  brc_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Random backpressure on the result side, quiet while calm is set.
  always @(posedge clk_i) begin
    out_stall <= !calm && ($urandom_range(99) < 20);
  end

  // Watchdog on cycles in which no channel moves a beat.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= StuckLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // One reading beat, with a random gap in front unless calm.
  task automatic send_reading(input logic [15:0] ut, input logic [15:0] up);
    while (!calm && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{raw_temp: ut, raw_pressure: up};
    do @(posedge clk_i); while (in_stall);
    readings_sent++;
  endtask

  // Let the pipeline empty out so calibration can change safely.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cal(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] cal [5];
    logic [15:0] ut, up;
    int          n;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset calibration: the temperature divisor is zero.
    send_reading(16'd27898, 16'd23843);
    send_reading(16'hFFFF, 16'h0000);

    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      case (ph)
        0: cal = '{32'h0198_FFB8, 32'hC7D1_7FE5, 32'h7FF5_5A71, 32'h182E_0004, 32'hDDF9_0B34};
        1: cal = '{32'h0198_FFB8, 32'hC7D1_0000, 32'h7FF5_5A71, 32'h182E_0004, 32'hDDF9_0B34};
        2: cal = '{default: 32'hFFFF_FFFF};
        3: cal = '{default: 32'h8000_8000};
        4: cal = '{default: 32'h7FFF_7FFF};
        default: foreach (cal[i]) cal[i] = $urandom();
      endcase
      write_cal(RegAc1Ac2, cal[0]);
      write_cal(RegAc3Ac4, cal[1]);
      write_cal(RegAc5Ac6, cal[2]);
      write_cal(RegB1B2, cal[3]);
      write_cal(RegMcMd, cal[4]);
      // Indexes past the last register must leave calibration alone.
      if (ph == 5)
        for (int k = 5; k < 8; k++) write_cal(3'(k), $urandom());

      if (ph == 0) begin
        // Typical sample and the corners of both raw fields.
        send_reading(16'd27898, 16'd23843);
        send_reading(16'h0000, 16'h0000);
        send_reading(16'hFFFF, 16'hFFFF);
        send_reading(16'h0000, 16'hFFFF);
        send_reading(16'hFFFF, 16'h0000);
        send_reading(16'h8000, 16'h8000);
        send_reading(16'h7FFF, 16'h7FFF);
        send_reading(16'h5A71, 16'h0001);
        send_reading(16'hAAAA, 16'h5555);
        send_reading(16'h5555, 16'hAAAA);
      end else if (ph == 1) begin
        // Zero pressure divisor.
        send_reading(16'd27898, 16'd23843);
        send_reading(16'hFFFF, 16'hFFFF);
      end

      calm = (ph == 2);
      n = (ph == 1) ? 60 : 225;
      for (int k = 0; k < n; k++) begin
        ut = 16'($urandom());
        up = 16'($urandom());
        if (ph == 0 && k % 2 == 0) begin
          ut = 16'($urandom_range(32000, 20000));
          up = 16'($urandom_range(45000, 15000));
        end
        send_reading(ut, up);
        // Once, hold off until every pending reading has come back.
        if (ph == 3 && k == 100) begin
          in_valid <= 1'b0;
          while (pending != 0) @(posedge clk_i);
        end
      end
      calm = 1'b0;
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d readings over %0d calibration sets, incl. divide-by-zero cases,",
             readings_sent, NumPhases + 1);
    $display("coefficient extremes, ignored register writes and random backpressure.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
